// ===== rtl/contiguous_segment_allocator_unit_defines.svh =====
// assertion macros used by the allocator controller
`ifndef CONTIGUOUS_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH
`define CONTIGUOUS_SEGMENT_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CSA_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/csa_pkg.sv =====
`default_nettype none
package csa_pkg;

	// default sizing
	localparam int MAX_SEGMENTS_DEF = 16;
	localparam int ADDR_BITS_DEF    = 30;

	// fixed field widths
	localparam int TAG_W    = 64;
	localparam int LEN_W    = 31;
	localparam int START_W  = 30;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 4;

	// operations
	localparam logic [OP_W-1:0] OP_REQUEST    = 3'd0;
	localparam logic [OP_W-1:0] OP_RELEASE    = 3'd1;
	localparam logic [OP_W-1:0] OP_FIND       = 3'd2;
	localparam logic [OP_W-1:0] OP_LIST_ALLOC = 3'd3;
	localparam logic [OP_W-1:0] OP_LIST_FREE  = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ALLOCATED   = 4'd0;
	localparam logic [STATUS_W-1:0] ST_REQ_FAILED  = 4'd1;
	localparam logic [STATUS_W-1:0] ST_FREED       = 4'd2;
	localparam logic [STATUS_W-1:0] ST_REL_FAILED  = 4'd3;
	localparam logic [STATUS_W-1:0] ST_FOUND       = 4'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 4'd5;
	localparam logic [STATUS_W-1:0] ST_LIST_ENTRY  = 4'd6;
	localparam logic [STATUS_W-1:0] ST_NONE        = 4'd7;
	localparam logic [STATUS_W-1:0] ST_FULL        = 4'd8;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 2'd1;
	localparam logic [LEN_W-1:0] REGION_SIZE_RST = 31'd1024;

	typedef struct packed {
		logic [TAG_W-1:0]   owner;
		logic [LEN_W-1:0]   length;
		logic [START_W-1:0] start;
	} entry_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [TAG_W-1:0] tag;
		logic [LEN_W-1:0] size;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TAG_W-1:0]    tag;
		logic [LEN_W-1:0]    length;
		logic [START_W-1:0]  start;
		logic                last;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/contiguous_segment_allocator_unit.sv =====
`default_nettype none
// Contiguous segment allocator.
// Input beats (s_*) carry one operation each: request, release, find, list
// allocated or list free gaps. The operation code rides on s_tuser, the owner
// tag and request size on s_tdata. Each operation returns one or more result
// beats on m_*, status on m_tuser, m_tlast set on the final beat of the run.
// Undefined operation codes are taken and give no result.
// Configuration writes (cfg_*) set region size (index 0) and fit mode
// (index 1); they are always taken and must only be issued while idle.
// One operation is worked at a time; s_tready is high only when idle.
// A scan reads the segment table one entry per cycle from a single memory,
// pausing while a listed result waits on m_tready. A placed request then
// shifts later entries up and writes the new entry; a release shifts later
// entries down.
// Results pass through one output register, so the next result is loaded in
// the same cycle the previous one is taken; a stall on m_tready holds the
// scan in place without losing or repeating a beat.
// Reset empties the table and restores region size 1024 and first fit; no
// clearing pass is needed.
module contiguous_segment_allocator_unit #(
	parameter int MAX_SEGMENTS = csa_pkg::MAX_SEGMENTS_DEF,
	parameter int ADDR_BITS    = csa_pkg::ADDR_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [95:0]                         s_tdata,  // owner_tag, request_size
	input  wire logic [csa_pkg::OP_W-1:0]            s_tuser,  // operation
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [127:0]                             m_tdata,  // result_tag, result_length, result_start
	output logic [csa_pkg::STATUS_W-1:0]             m_tuser,  // status
	output logic                                     m_tlast,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [csa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [csa_pkg::LEN_W-1:0]           cfg_data
);
	import csa_pkg::*;

	localparam int AW = $clog2(MAX_SEGMENTS);

	item_t           item;
	res_t            res;
	logic            res_valid;
	logic            res_ready;
	res_t            out_res;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [AW-1:0]   mem_raddr;
	entry_t          mem_wdata;
	entry_t          mem_rdata;

	// unpack input beat
	assign item.op   = s_tuser;
	assign item.tag  = s_tdata[TAG_W-1:0];
	assign item.size = s_tdata[TAG_W+LEN_W-1:TAG_W];

	assign cfg_ready = 1'b1;

	csa_ctrl #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.ADDR_BITS(ADDR_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(s_tvalid),
		.item(item),
		.item_ready(s_tready),
		.cfg_we(cfg_valid),
		.cfg_idx(cfg_index),
		.cfg_val(cfg_data),
		.res_valid(res_valid),
		.res(res),
		.res_ready(res_ready),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	csa_seg_mem #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	csa_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(res_valid),
		.in_data(res),
		.in_ready(res_ready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(out_res)
	);

	// pack result beat
	assign m_tdata = {3'b000, out_res.start, out_res.length, out_res.tag};
	assign m_tuser = out_res.status;
	assign m_tlast = out_res.last;

endmodule
`default_nettype wire

// ===== rtl/csa_seg_mem.sv =====
`default_nettype none
module csa_seg_mem #(
	parameter int MAX_SEGMENTS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              we,
	input  wire logic [$clog2(MAX_SEGMENTS)-1:0]   waddr,
	input  wire csa_pkg::entry_t                   wdata,
	input  wire logic [$clog2(MAX_SEGMENTS)-1:0]   raddr,
	output csa_pkg::entry_t                        rdata
);
	import csa_pkg::*;

	entry_t mem [MAX_SEGMENTS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/csa_out_reg.sv =====
`default_nettype none
module csa_out_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire csa_pkg::res_t in_data,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output csa_pkg::res_t      out_data
);
	import csa_pkg::*;

	logic valid_q;
	res_t data_q;

	// slot frees when empty or taken this cycle
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/csa_ctrl.sv =====
`default_nettype none
`include "contiguous_segment_allocator_unit_defines.svh"
module csa_ctrl #(
	parameter int MAX_SEGMENTS = 16,
	parameter int ADDR_BITS    = 30
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   item_valid,
	input  wire csa_pkg::item_t                         item,
	output logic                                        item_ready,
	input  wire logic                                   cfg_we,
	input  wire logic [csa_pkg::CFG_IDX_W-1:0]          cfg_idx,
	input  wire logic [csa_pkg::LEN_W-1:0]              cfg_val,
	output logic                                        res_valid,
	output csa_pkg::res_t                               res,
	input  wire logic                                   res_ready,
	output logic                                        mem_we,
	output logic [$clog2(MAX_SEGMENTS)-1:0]             mem_waddr,
	output csa_pkg::entry_t                             mem_wdata,
	output logic [$clog2(MAX_SEGMENTS)-1:0]             mem_raddr,
	input  wire csa_pkg::entry_t                        mem_rdata
);
	import csa_pkg::*;

	localparam int AW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);
	localparam logic [31:0] REGION_LIM = 32'(1) << ADDR_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_SHUP = 3'd2;
	localparam logic [2:0] S_INS  = 3'd3;
	localparam logic [2:0] S_SHDN = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0]         state_q;
	logic [OP_W-1:0]    op_q;
	logic [TAG_W-1:0]   tag_q;
	logic [LEN_W-1:0]   size_q;
	logic [CW-1:0]      count_q;
	logic [LEN_W-1:0]   used_q;
	logic [LEN_W-1:0]   region_q;
	logic               fit_q;
	logic [CW-1:0]      idx_q;
	logic [31:0]        prev_end_q;
	logic               have_q;
	logic [CW-1:0]      best_idx_q;
	logic [LEN_W-1:0]   best_len_q;
	logic [START_W-1:0] best_start_q;
	logic [CW-1:0]      rptr_q;
	logic [CW-1:0]      wptr_q;
	logic               dv_q;
	logic [CW-1:0]      n_q;
	logic               pend_vld_q;
	logic [LEN_W-1:0]   pend_len_q;
	logic [START_W-1:0] pend_start_q;
	res_t               res_q;

	logic [31:0]        usable;
	logic [31:0]        avail;
	logic               pre_fail;
	logic               tail;
	logic [31:0]        gap_end;
	logic [31:0]        gap_len32;
	logic [LEN_W-1:0]   gap_len;
	logic [31:0]        seg_end;
	logic               take;
	logic               hit;
	logic               adv;
	logic               shup_rd;
	logic               shdn_rd;
	logic [CW-1:0]      rd_addr_c;
	logic [CW-1:0]      sel_idx;
	logic               push;

	// region limit and free space
	assign usable   = ({1'b0, region_q} > REGION_LIM) ? REGION_LIM : {1'b0, region_q};
	assign avail    = (usable > {1'b0, used_q}) ? usable - {1'b0, used_q} : 32'd0;
	assign pre_fail = (item.size == '0) || ({1'b0, item.size} > avail) || (count_q >= CNT_MAX);

	// gap in front of the entry under scan, trailing gap at the end
	assign tail      = idx_q == count_q;
	assign gap_end   = tail ? usable : {2'b0, mem_rdata.start};
	assign gap_len32 = (gap_end > prev_end_q) ? gap_end - prev_end_q : 32'd0;
	assign gap_len   = gap_len32[LEN_W-1:0];
	assign seg_end   = {2'b0, mem_rdata.start} + {1'b0, mem_rdata.length};
	assign take      = (gap_len >= size_q) && (!have_q || (fit_q && gap_len < best_len_q));
	assign hit       = !tail && (mem_rdata.owner == tag_q);
	assign sel_idx   = take ? idx_q : best_idx_q;

	assign shup_rd = (state_q == S_SHUP) && (n_q != '0);
	assign shdn_rd = (state_q == S_SHDN) && (rptr_q < count_q);

	assign item_ready = state_q == S_IDLE;
	assign push       = res_valid && res_ready;

	// result source and scan stall
	always_comb begin
		res_valid = 1'b0;
		res       = res_q;
		adv       = 1'b1;
		case (state_q)
			S_EMIT: begin
				res_valid = 1'b1;
			end
			S_SCAN: begin
				if (op_q == OP_LIST_ALLOC && !tail) begin
					res_valid = 1'b1;
					res = '{status: ST_LIST_ENTRY, tag: mem_rdata.owner,
						length: mem_rdata.length, start: mem_rdata.start,
						last: idx_q == count_q - CW'(1)};
					adv = res_ready;
				end else if (op_q == OP_LIST_FREE && pend_vld_q && gap_len != '0) begin
					res_valid = 1'b1;
					res = '{status: ST_LIST_ENTRY, tag: '0, length: pend_len_q,
						start: pend_start_q, last: 1'b0};
					adv = res_ready;
				end
			end
			default: begin
			end
		endcase
	end

	// read address per state
	always_comb begin
		case (state_q)
			S_SCAN:  rd_addr_c = adv ? idx_q + CW'(1) : idx_q;
			S_SHUP:  rd_addr_c = best_idx_q + n_q - CW'(1);
			S_SHDN:  rd_addr_c = rptr_q;
			default: rd_addr_c = '0;
		endcase
	end
	assign mem_raddr = rd_addr_c[AW-1:0];

	// write port: shift moves and the new entry
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wptr_q[AW-1:0];
		mem_wdata = mem_rdata;
		case (state_q)
			S_SHUP, S_SHDN: begin
				mem_we = dv_q;
			end
			S_INS: begin
				mem_we    = 1'b1;
				mem_waddr = best_idx_q[AW-1:0];
				mem_wdata = '{owner: tag_q, length: size_q, start: best_start_q};
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= REGION_SIZE_RST;
			fit_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_REGION_SIZE: region_q <= cfg_val;
				REG_FIT_MODE:    fit_q    <= cfg_val[0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			used_q     <= '0;
			dv_q       <= 1'b0;
			have_q     <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						op_q       <= item.op;
						tag_q      <= item.tag;
						size_q     <= item.size;
						idx_q      <= '0;
						prev_end_q <= '0;
						have_q     <= 1'b0;
						pend_vld_q <= 1'b0;
						dv_q       <= 1'b0;
						case (item.op)
							OP_REQUEST: begin
								if (pre_fail) begin
									res_q   <= '{status: ST_REQ_FAILED, tag: item.tag,
										length: item.size, start: '0, last: 1'b1};
									state_q <= S_EMIT;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_RELEASE, OP_FIND, OP_LIST_ALLOC, OP_LIST_FREE: begin
								state_q <= S_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (adv) begin
						idx_q      <= idx_q + CW'(1);
						prev_end_q <= seg_end;
					end
					case (op_q)
						OP_REQUEST: begin
							if (take) begin
								have_q       <= 1'b1;
								best_idx_q   <= idx_q;
								best_len_q   <= gap_len;
								best_start_q <= prev_end_q[START_W-1:0];
							end
							if ((take && !fit_q) || tail) begin
								if (take || have_q) begin
									n_q     <= count_q - sel_idx;
									state_q <= (count_q == sel_idx) ? S_INS : S_SHUP;
								end else begin
									res_q   <= '{status: ST_REQ_FAILED, tag: tag_q,
										length: size_q, start: '0, last: 1'b1};
									state_q <= S_EMIT;
								end
							end
						end
						OP_RELEASE, OP_FIND: begin
							if (tail) begin
								res_q   <= '{status: (op_q == OP_FIND) ? ST_NOT_FOUND
									: ST_REL_FAILED, tag: tag_q, length: '0, start: '0,
									last: 1'b1};
								state_q <= S_EMIT;
							end else if (hit) begin
								res_q <= '{status: (op_q == OP_FIND) ? ST_FOUND : ST_FREED,
									tag: tag_q, length: mem_rdata.length,
									start: mem_rdata.start, last: 1'b1};
								if (op_q == OP_FIND) begin
									state_q <= S_EMIT;
								end else begin
									used_q  <= (used_q > mem_rdata.length)
										? used_q - mem_rdata.length : '0;
									rptr_q  <= idx_q + CW'(1);
									state_q <= S_SHDN;
								end
							end
						end
						OP_LIST_ALLOC: begin
							if (tail) begin
								res_q   <= '{status: ST_NONE, tag: '0, length: '0,
									start: '0, last: 1'b1};
								state_q <= S_EMIT;
							end else if (push && res.last) begin
								state_q <= S_IDLE;
							end
						end
						default: begin
							// list free gaps, one result held back to mark the last
							if (tail) begin
								if (gap_len != '0) begin
									if (!pend_vld_q || res_ready) begin
										res_q   <= '{status: ST_LIST_ENTRY, tag: '0,
											length: gap_len,
											start: prev_end_q[START_W-1:0], last: 1'b1};
										state_q <= S_EMIT;
									end
								end else if (pend_vld_q) begin
									res_q   <= '{status: ST_LIST_ENTRY, tag: '0,
										length: pend_len_q, start: pend_start_q,
										last: 1'b1};
									state_q <= S_EMIT;
								end else begin
									res_q   <= '{status: ST_FULL, tag: '0, length: '0,
										start: '0, last: 1'b1};
									state_q <= S_EMIT;
								end
							end else if (adv && gap_len != '0) begin
								pend_vld_q   <= 1'b1;
								pend_len_q   <= gap_len;
								pend_start_q <= prev_end_q[START_W-1:0];
							end
						end
					endcase
				end
				S_SHUP: begin
					dv_q   <= shup_rd;
					wptr_q <= best_idx_q + n_q;
					if (shup_rd) begin
						n_q <= n_q - CW'(1);
					end else if (!dv_q) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					count_q <= count_q + CW'(1);
					used_q  <= used_q + size_q;
					res_q   <= '{status: ST_ALLOCATED, tag: tag_q, length: size_q,
						start: best_start_q, last: 1'b1};
					state_q <= S_EMIT;
				end
				S_SHDN: begin
					dv_q   <= shdn_rd;
					wptr_q <= rptr_q - CW'(1);
					if (shdn_rd) begin
						rptr_q <= rptr_q + CW'(1);
					end else if (!dv_q) begin
						count_q <= count_q - CW'(1);
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`CSA_ASSERT(a_count_bound, 1'b1, count_q <= CNT_MAX, "segment count above table depth")
	`CSA_ASSERT(a_scan_bound, state_q == S_SCAN, idx_q <= count_q, "scan ran past last entry")
	`CSA_ASSERT(a_shift_apart, mem_we && (shup_rd || shdn_rd), mem_waddr != mem_raddr, "shift read and write hit the same entry")
	`CSA_ASSERT(a_idle_no_write, state_q == S_IDLE || state_q == S_SCAN, !mem_we, "table written outside an update")
	`CSA_ASSERT_NEXT(a_ins_grows, state_q == S_INS, count_q == $past(count_q) + CW'(1), "insert did not grow the table")

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
module tb_top;
	import csa_pkg::*;

	localparam int WDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 2 * MAX_SEGMENTS_DEF + 20;
	localparam longint unsigned ADDR_SPAN = 64'd1 << ADDR_BITS_DEF;
	localparam logic [LEN_W-1:0] LEN_MASK = '1;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [95:0] s_tdata;
	logic [OP_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [127:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0] cfg_data;

	contiguous_segment_allocator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// allocator shadow state
	longint unsigned seg_start [MAX_SEGMENTS_DEF];
	longint unsigned seg_len [MAX_SEGMENTS_DEF];
	longint unsigned seg_owner [MAX_SEGMENTS_DEF];
	int unsigned seg_count;
	longint unsigned used_units;
	longint unsigned region_size;
	bit best_fit;

	res_t pending_results [$];
	longint unsigned tag_pool [8];
	int error_count;
	bit quiet;

	// clock and reset
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	function automatic longint unsigned usable_units();
		return (region_size > ADDR_SPAN) ? ADDR_SPAN : region_size;
	endfunction

	// gap g sits before segment g; gap seg_count trails the table
	function automatic void gap_bounds(int unsigned g, output longint unsigned gs,
			output longint unsigned gl);
		longint unsigned e;
		gs = (g > 0) ? seg_start[g-1] + seg_len[g-1] : 0;
		e = (g >= seg_count) ? usable_units() : seg_start[g];
		gl = (e > gs) ? e - gs : 0;
	endfunction

	function automatic void push_result(logic [STATUS_W-1:0] st, longint unsigned tag,
			longint unsigned len, longint unsigned start);
		res_t r;
		r.status = st;
		r.tag = tag;
		r.length = len[LEN_W-1:0];
		r.start = start[START_W-1:0];
		r.last = 0;
		pending_results.push_back(r);
	endfunction

	function automatic int find_owner(longint unsigned tag);
		for (int i = 0; i < seg_count; i++)
			if (seg_owner[i] == tag)
				return i;
		return -1;
	endfunction

	function automatic void place_segment(longint unsigned tag, longint unsigned size);
		longint unsigned avail, gs, gl, pick_len, pick_start;
		int pick;
		bit found;
		avail = (usable_units() > used_units) ? usable_units() - used_units : 0;
		found = 0;
		pick = 0;
		pick_len = 0;
		pick_start = 0;
		if (size == 0 || size > avail || seg_count >= MAX_SEGMENTS_DEF) begin
			push_result(ST_REQ_FAILED, tag, size, 0);
			return;
		end
		for (int g = 0; g <= seg_count; g++) begin
			gap_bounds(g, gs, gl);
			if (gl >= size && (!found || (best_fit && gl < pick_len))) begin
				found = 1;
				pick = g;
				pick_len = gl;
				pick_start = gs;
				if (!best_fit)
					break;
			end
		end
		if (!found) begin
			push_result(ST_REQ_FAILED, tag, size, 0);
			return;
		end
		for (int i = seg_count; i > pick; i--) begin
			seg_start[i] = seg_start[i-1];
			seg_len[i] = seg_len[i-1];
			seg_owner[i] = seg_owner[i-1];
		end
		seg_start[pick] = pick_start & ((64'd1 << START_W) - 1);
		seg_len[pick] = size;
		seg_owner[pick] = tag;
		seg_count++;
		used_units = (used_units + size) & LEN_MASK;
		push_result(ST_ALLOCATED, tag, size, pick_start);
	endfunction

	// works out every result of one accepted operation
	function automatic void predict_operation(logic [OP_W-1:0] op, longint unsigned tag,
			longint unsigned size);
		int idx, before_n;
		longint unsigned gs, gl;
		before_n = pending_results.size();
		case (op)
			OP_REQUEST: begin
				place_segment(tag, size);
			end
			OP_RELEASE: begin
				idx = find_owner(tag);
				if (idx < 0) begin
					push_result(ST_REL_FAILED, tag, 0, 0);
				end else begin
					push_result(ST_FREED, tag, seg_len[idx], seg_start[idx]);
					used_units = (used_units > seg_len[idx]) ? used_units - seg_len[idx] : 0;
					for (int i = idx; i + 1 < seg_count; i++) begin
						seg_start[i] = seg_start[i+1];
						seg_len[i] = seg_len[i+1];
						seg_owner[i] = seg_owner[i+1];
					end
					seg_count--;
				end
			end
			OP_FIND: begin
				idx = find_owner(tag);
				if (idx < 0)
					push_result(ST_NOT_FOUND, tag, 0, 0);
				else
					push_result(ST_FOUND, tag, seg_len[idx], seg_start[idx]);
			end
			OP_LIST_ALLOC: begin
				for (int i = 0; i < seg_count; i++)
					push_result(ST_LIST_ENTRY, seg_owner[i], seg_len[i], seg_start[i]);
				if (seg_count == 0)
					push_result(ST_NONE, 0, 0, 0);
			end
			OP_LIST_FREE: begin
				for (int g = 0; g <= seg_count; g++) begin
					gap_bounds(g, gs, gl);
					if (gl > 0)
						push_result(ST_LIST_ENTRY, 0, gl, gs);
				end
				if (pending_results.size() == before_n)
					push_result(ST_FULL, 0, 0, 0);
			end
			default: ;
		endcase
		if (pending_results.size() > before_n)
			pending_results[$].last = 1;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat, status", m_tuser, 0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status)
					report_mismatch("status", m_tuser, want.status);
				if (m_tdata[63:0] !== want.tag)
					report_mismatch("result_tag", m_tdata[63:0], want.tag);
				if (m_tdata[94:64] !== want.length)
					report_mismatch("result_length", m_tdata[94:64], want.length);
				if (m_tdata[124:95] !== want.start)
					report_mismatch("result_start", m_tdata[124:95], want.start);
				if (m_tlast !== want.last)
					report_mismatch("last_of_run", m_tlast, want.last);
			end
		end
	end

	// receiver stalls
	initial begin
		int unsigned n;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			n = quiet ? 0 : $urandom_range(0, 12);
			if (n > 0) begin
				m_tready <= 0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// watchdog on cycles with no beat moving
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("** contiguous_segment_allocator_unit: FAILED **");
				$finish;
			end
		end
	end

	// one operation beat, valid held high across back-to-back beats
	task automatic send_operation(logic [OP_W-1:0] op, longint unsigned tag,
			longint unsigned size);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {1'b0, size[LEN_W-1:0], tag};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_operation(op, tag, size & LEN_MASK);
	endtask

	// wait for every result, then let the block settle
	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(longint unsigned region, bit fit);
		drain();
		cfg_valid <= 1;
		cfg_index <= REG_REGION_SIZE;
		cfg_data <= region[LEN_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		region_size = region & LEN_MASK;
		cfg_index <= REG_FIT_MODE;
		cfg_data <= LEN_W'(fit);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		best_fit = fit;
		cfg_valid <= 0;
	endtask

	function automatic longint unsigned pick_size();
		longint unsigned cap;
		cap = usable_units() / 10;
		if (cap < 1)
			cap = 1;
		case ($urandom_range(0, 11))
			0: return 0;
			1: return {$urandom} & LEN_MASK;
			2: return usable_units();
			3: return (64'd1 << 30);
			default: return $urandom_range(1, (cap > 64'hffff) ? 32'hffff : cap);
		endcase
	endfunction

	function automatic longint unsigned pick_tag();
		if ($urandom_range(0, 9) == 0)
			return {$urandom, $urandom};
		return tag_pool[$urandom_range(0, 7)];
	endfunction

	task automatic test_directed();
		quiet = 0;
		send_operation(OP_LIST_ALLOC, 0, 0);
		send_operation(OP_LIST_FREE, 0, 0);
		send_operation(OP_REQUEST, tag_pool[0], 0);
		send_operation(OP_RELEASE, tag_pool[1], 5);
		send_operation(OP_FIND, tag_pool[1], 0);
		send_operation(OP_REQUEST, tag_pool[0], 100);
		send_operation(OP_REQUEST, 64'hffff_ffff_ffff_ffff, 200);
		send_operation(OP_REQUEST, tag_pool[0], 50);
		send_operation(OP_REQUEST, 0, 2000);
		send_operation(OP_REQUEST, 0, 64'h7fff_ffff);
		send_operation(OP_FIND, tag_pool[0], 0);
		send_operation(OP_RELEASE, tag_pool[0], 0);
		send_operation(OP_LIST_ALLOC, 0, 0);
		send_operation(OP_LIST_FREE, 0, 0);
		send_operation(3'd5, tag_pool[2], 7);
		send_operation(3'd6, 0, 0);
		send_operation(3'd7, '1, 64'h7fff_ffff);
		send_operation(OP_FIND, 64'hffff_ffff_ffff_ffff, 0);
	endtask

	// fill a tiny region and the whole table, then best fit into holes
	task automatic test_full_table();
		set_config(16, 1);
		quiet = 1;
		send_operation(OP_RELEASE, 64'hffff_ffff_ffff_ffff, 0);
		send_operation(OP_RELEASE, tag_pool[0], 0);
		for (int i = 0; i < MAX_SEGMENTS_DEF; i++)
			send_operation(OP_REQUEST, tag_pool[i % 8], 1);
		send_operation(OP_REQUEST, tag_pool[3], 1);
		send_operation(OP_LIST_FREE, 0, 0);
		send_operation(OP_LIST_ALLOC, 0, 0);
		quiet = 0;
		set_config(24, 1);
		send_operation(OP_REQUEST, tag_pool[4], 1);
		for (int i = 0; i < 3; i++)
			send_operation(OP_RELEASE, tag_pool[i], 0);
		send_operation(OP_LIST_FREE, 0, 0);
		send_operation(OP_REQUEST, tag_pool[5], 2);
		send_operation(OP_REQUEST, tag_pool[6], 1);
	endtask

	// region shrinks under existing segments
	task automatic test_shrink();
		set_config(64'h7fff_ffff, 0);
		send_operation(OP_REQUEST, tag_pool[7], 64'h4000_0000);
		send_operation(OP_LIST_FREE, 0, 0);
		set_config(16, 0);
		send_operation(OP_LIST_FREE, 0, 0);
		send_operation(OP_LIST_ALLOC, 0, 0);
		send_operation(OP_REQUEST, tag_pool[7], 1);
		for (int i = 0; i < 8; i++)
			send_operation(OP_RELEASE, tag_pool[i], 0);
	endtask

	task automatic test_random(int unsigned items);
		longint unsigned region_opts [5];
		int unsigned op_roll;
		logic [OP_W-1:0] op;
		region_opts = '{1024, 16, 300, 64'h4000_0000, 64'h7fff_ffff};
		for (int ph = 0; ph < 5; ph++) begin
			set_config(region_opts[ph], ph[0]);
			quiet = (ph == 2);
			for (int k = 0; k < items / 5; k++) begin
				op_roll = $urandom_range(0, 99);
				if (op_roll < 40) op = OP_REQUEST;
				else if (op_roll < 62) op = OP_RELEASE;
				else if (op_roll < 74) op = OP_FIND;
				else if (op_roll < 84) op = OP_LIST_ALLOC;
				else if (op_roll < 94) op = OP_LIST_FREE;
				else op = 3'($urandom_range(5, 7));
				send_operation(op, pick_tag(), pick_size());
			end
		end
	endtask

	initial begin
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		error_count = 0;
		quiet = 0;
		seg_count = 0;
		used_units = 0;
		region_size = REGION_SIZE_RST;
		best_fit = 0;
		tag_pool[0] = 0;
		tag_pool[1] = 64'hffff_ffff_ffff_ffff;
		for (int i = 2; i < 8; i++)
			tag_pool[i] = {$urandom, $urandom};
		@(posedge arst_n);
		@(posedge clk);

		test_directed();
		test_full_table();
		test_shrink();
		test_random(160);
		drain();

		if (error_count == 0)
			$display("** contiguous_segment_allocator_unit: PASSED **");
		else
			$display("** contiguous_segment_allocator_unit: FAILED **");
		$finish;
	end

endmodule

// ===== contiguous_segment_allocator_unit.f =====
+incdir+rtl
rtl/csa_pkg.sv
rtl/csa_seg_mem.sv
rtl/csa_out_reg.sv
rtl/csa_ctrl.sv
rtl/contiguous_segment_allocator_unit.sv
test/tb_top.sv
